@@ rtl/bgcd_pkg.sv @@
// Shared constants for the binary gcd core and its port checker.
// No dependencies.
`timescale 1ns / 1ps

package bgcd_pkg;

   // Step stages per operand bit. Each step removes at least one bit from
   // the combined length of the two operands, so two per bit always suffice.
   localparam int unsigned STEPS_PER_BIT = 2;

   // Registers around the step stages: the entry stage and the output stage.
   localparam int unsigned EDGE_STAGES = 2;

endpackage

@@ rtl/binary_gcd_core.sv @@
// Binary (Stein) gcd core, built as a fixed-length pipeline of step stages.
// Depends on bgcd_pkg.
`timescale 1ns / 1ps

// The core takes one operand pair on every clock cycle (busy is always low)
// and returns its greatest common divisor, one result per accepted pair, in
// order. The pair passes the entry stage, a chain of 2*WIDTH step stages,
// each doing one subtract-and-halve or halving step on a pair of WIDTH-bit
// values, and the output stage. The receiver cannot stall: rsp_valid marks
// the result for one cycle. If either operand is zero the result is the
// other operand; both zero gives zero.
module binary_gcd_core
   import bgcd_pkg::*;
#(
   parameter int unsigned WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [WIDTH-1:0] req_a_operand,
   input  logic [WIDTH-1:0] req_b_operand,
   output logic             rsp_valid,
   output logic [WIDTH-1:0] rsp_divisor
);

   localparam int unsigned STEPS = STEPS_PER_BIT * WIDTH;
   localparam int unsigned KW    = $clog2(WIDTH);

   logic [WIDTH-1:0] a_ff [0:STEPS];
   logic [WIDTH-1:0] b_ff [0:STEPS];
   logic [KW-1:0]    k_ff [0:STEPS];
   logic             done_ff  [0:STEPS];
   logic             valid_ff [0:STEPS];

   logic [WIDTH-1:0] a_in [1:STEPS];
   logic [WIDTH-1:0] b_in [1:STEPS];
   logic [KW-1:0]    k_in [1:STEPS];
   logic             done_in [1:STEPS];

   logic             out_valid_ff;
   logic [WIDTH-1:0] out_divisor_ff;
   logic             zero_op;

   // Every stage moves on each cycle, so the core is never busy.
   assign busy    = 1'b0;
   assign zero_op = (req_a_operand == '0) || (req_b_operand == '0);

   // Entry stage: a zero operand finishes at once with the other operand.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= start;
      end
      a_ff[0]    <= zero_op ? (req_a_operand | req_b_operand) : req_a_operand;
      b_ff[0]    <= req_b_operand;
      k_ff[0]    <= '0;
      done_ff[0] <= zero_op;
   end

   // Step stages: one Stein step each, holding once the pair has converged.
   for (genvar s = 0; s < STEPS; s++) begin : g_step
      logic [WIDTH:0] diff;

      assign diff = {1'b0, a_ff[s]} - {1'b0, b_ff[s]};

      always_comb begin
         a_in[s+1]    = a_ff[s];
         b_in[s+1]    = b_ff[s];
         k_in[s+1]    = k_ff[s];
         done_in[s+1] = done_ff[s];
         if (!done_ff[s]) begin
            if (a_ff[s] == b_ff[s]) begin
               done_in[s+1] = 1'b1;
            end else if (!a_ff[s][0] && !b_ff[s][0]) begin
               // Common factor of two, counted for the final shift.
               a_in[s+1] = a_ff[s] >> 1;
               b_in[s+1] = b_ff[s] >> 1;
               k_in[s+1] = k_ff[s] + KW'(1);
            end else if (!a_ff[s][0]) begin
               a_in[s+1] = a_ff[s] >> 1;
            end else if (!b_ff[s][0]) begin
               b_in[s+1] = b_ff[s] >> 1;
            end else if (diff[WIDTH]) begin
               // Borrow out: b is the larger, so it takes the halved difference.
               b_in[s+1] = WIDTH'((~diff + 1'b1) >> 1);
            end else begin
               a_in[s+1] = diff[WIDTH:1];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else begin
            valid_ff[s+1] <= valid_ff[s];
         end
         a_ff[s+1]    <= a_in[s+1];
         b_ff[s+1]    <= b_in[s+1];
         k_ff[s+1]    <= k_in[s+1];
         done_ff[s+1] <= done_in[s+1];
      end
   end

   // Output stage: restore the common power of two.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= valid_ff[STEPS] && done_ff[STEPS];
      end
      out_divisor_ff <= a_ff[STEPS] << k_ff[STEPS];
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_divisor = out_divisor_ff;

endmodule

@@ rtl/bgcd_checker.sv @@
// Port-level checker for the binary gcd core, with its bind statement.
// Depends on bgcd_pkg and binary_gcd_core.
`timescale 1ns / 1ps

module bgcd_checker
   import bgcd_pkg::*;
#(
   parameter int unsigned WIDTH = 32
) (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic [WIDTH-1:0] req_a_operand,
   input logic [WIDTH-1:0] req_b_operand,
   input logic             rsp_valid,
   input logic [WIDTH-1:0] rsp_divisor
);

   localparam int unsigned LATENCY = STEPS_PER_BIT * WIDTH + EDGE_STAGES;

   // The pipeline never refuses a transfer.
   assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   // Every result traces back to a transfer a fixed latency earlier.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY))
      else $error("result without a matching transfer");

   // A zero result comes only from two zero operands.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_divisor == '0) |->
         ($past(req_a_operand, LATENCY) == '0 && $past(req_b_operand, LATENCY) == '0))
      else $error("zero divisor from nonzero operands");

   // A zero first operand passes the second operand through.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_a_operand, LATENCY) == '0) |->
         (rsp_divisor == $past(req_b_operand, LATENCY)))
      else $error("zero operand not passed through");

endmodule

bind binary_gcd_core bgcd_checker #(.WIDTH(WIDTH)) u_bgcd_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_a_operand (req_a_operand),
   .req_b_operand (req_b_operand),
   .rsp_valid     (rsp_valid),
   .rsp_divisor   (rsp_divisor)
);

@@ verif/binary_gcd_core_tb.sv @@
// Self-checking testbench for binary_gcd_core: drives operand pairs, predicts
// each gcd and compares results in order. Depends on bgcd_pkg and the core.
`timescale 1ns / 1ps

// In-order store of predicted divisors, compared against each result.
class gcd_scoreboard;
   logic [31:0] pending_divisors[$];
   int unsigned mismatches;
   int unsigned failures;

   // Stein gcd with the order of the operands taken from a 33-bit borrow.
   function automatic logic [31:0] stein_gcd(logic [31:0] a, logic [31:0] b);
      int unsigned shift;
      logic [32:0] diff;
      logic [31:0] t;
      if (a == 0) return b;
      if (b == 0) return a;
      shift = 0;
      while (((a | b) >> shift) % 2 == 0) shift++;
      while (a[0] == 1'b0) a = a >> 1;
      do begin
         while (b[0] == 1'b0) b = b >> 1;
         diff = {1'b0, b} - {1'b0, a};
         if (diff[32]) begin
            t = a;
            a = b;
            b = t;
         end
         b = b - a;
      end while (b != 0);
      return a << shift;
   endfunction

   function void note_operands(logic [31:0] a, logic [31:0] b);
      pending_divisors.push_back(stein_gcd(a, b));
   endfunction

   function void check_divisor(logic [31:0] actual);
      logic [31:0] expected;
      if (pending_divisors.size() == 0) begin
         failures++;
         $display("ERROR: unexpected result %h", actual);
         return;
      end
      expected = pending_divisors.pop_front();
      if (expected !== actual) begin
         failures++;
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: divisor expected %h actual %h", expected, actual);
      end
   endfunction
endclass

module binary_gcd_core_tb;
   import bgcd_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [31:0] req_a_operand = '0;
   logic [31:0] req_b_operand = '0;
   logic        rsp_valid;
   logic [31:0] rsp_divisor;
   gcd_scoreboard board = new();
   localparam int unsigned LATENCY = STEPS_PER_BIT * 32 + EDGE_STAGES;

   binary_gcd_core #(.WIDTH(32)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_a_operand(req_a_operand), .req_b_operand(req_b_operand),
      .rsp_valid(rsp_valid), .rsp_divisor(rsp_divisor)
   );

   always #1 clock = ~clock;

   // Results are sampled at the rising edge that ends their strobe cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check_divisor(rsp_divisor);
   end

   // Random idle cycles, mostly short and sometimes long. Start drops only
   // when a gap is actually taken, so back-to-back transfers keep it high.
   task automatic idle_gap();
      int unsigned n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) n = 0;
      if (n != 0) begin
         start <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   // One transfer: hold start until an edge with busy low accepts it. Start
   // stays high afterward; the caller drops it before an idle stretch.
   task automatic send_pair(logic [31:0] a, logic [31:0] b);
      req_a_operand <= a;
      req_b_operand <= b;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      board.note_operands(a, b);
      @(negedge clock);
   endtask

   // Operand with a random number of trailing zeros and random magnitude.
   function automatic logic [31:0] shaped_operand();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 4))
         0: v = v >> $urandom_range(0, 31);
         1: v = v << $urandom_range(0, 31);
         2: v = v | 32'h8000_0000;
         default: ;
      endcase
      if ($urandom_range(0, 30) == 0) v = '0;
      return v;
   endfunction

   initial begin
      logic [31:0] base;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // Directed pairs: zeros, extremes, wide differences, shared powers of two.
      send_pair(0, 0);
      send_pair(0, 32'hFFFF_FFFF);
      send_pair(32'hFFFF_FFFF, 0);
      send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_pair(1, 32'hFFFF_FFFF);
      send_pair(32'h8000_0000, 32'h8000_0000);
      send_pair(32'h8000_0000, 1);
      send_pair(32'hFFFF_FFFF, 1);
      send_pair(3, 32'h8000_0001);
      send_pair(32'hFFFF_FFFE, 6);
      send_pair(32'h8000_0000, 32'hC000_0000);
      send_pair(12, 18);
      send_pair(48, 180);
      send_pair(32'h5555_5555, 32'hAAAA_AAAA);
      send_pair(7, 7);
      send_pair(32'h0001_0000, 32'h0000_0100);
      start <= 1'b0;
      // Hold off until every pending result has come.
      while (board.pending_divisors.size() != 0) @(negedge clock);
      repeat (LATENCY) @(negedge clock);
      for (int i = 0; i < 440; i++) begin
         if (i == 220) begin
            start <= 1'b0;
            while (board.pending_divisors.size() != 0) @(negedge clock);
         end
         if ($urandom_range(0, 2) == 0) begin
            // Pairs with a large shared factor.
            base = $urandom >> $urandom_range(8, 28);
            send_pair(base * $urandom_range(1, 255), base * $urandom_range(1, 255));
         end else begin
            send_pair(shaped_operand(), shaped_operand());
         end
         if ($urandom_range(0, 3) != 0) idle_gap();
      end
      start <= 1'b0;
      while (board.pending_divisors.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
      if (board.failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #200000;
      $display("Simulation FAILED");
      $finish;
   end
endmodule

@@ binary_gcd_core.f @@
rtl/bgcd_pkg.sv
rtl/binary_gcd_core.sv
rtl/bgcd_checker.sv
verif/binary_gcd_core_tb.sv
